[rtl/multiplicative_hash_map_defines.svh]
// Assertion macros for the hash map RTL.
// MHM_CHECK is quiet while reset is asserted; MHM_CHECK_ALL runs on every edge.
`ifndef MULTIPLICATIVE_HASH_MAP_DEFINES_SVH
`define MULTIPLICATIVE_HASH_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define MHM_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hash map check failed");
`define MHM_CHECK_ALL(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("hash map check failed");
`else
`define MHM_CHECK(lbl, prop)
`define MHM_CHECK_ALL(lbl, prop)
`endif
`endif

[rtl/mhm_pkg.sv]
package mhm_pkg;

	localparam int unsigned BUCKETS_DEF = 1024;
	localparam int unsigned WAYS_DEF    = 4;

	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	// operation codes
	localparam logic [1:0] FN_FIND   = 2'd0;
	localparam logic [1:0] FN_INSERT = 2'd1;
	localparam logic [1:0] FN_REMOVE = 2'd2;
	localparam logic [1:0] FN_RSVD   = 2'd3;

	// status codes
	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_MISS = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] key;
		logic [31:0]        handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_handle;
	} rsp_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_UPDATE
	} state_t;

endpackage

[rtl/mhm_hash.sv]
module mhm_hash #(
	parameter int unsigned BUCKETS = mhm_pkg::BUCKETS_DEF,
	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   key,
	output logic          done,
	output logic [BW-1:0] bucket
);
	import mhm_pkg::*;

	localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

	logic [31:0] h_q;

	generate
		if (POW2) begin : g_mask
			logic run_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q <= 1'b0;
				end else begin
					run_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					h_q <= 32'(key * HASH_MULT);
				end
			end

			assign done = run_q;
			if (BUCKETS == 1) begin : g_one
				assign bucket = '0;
			end else begin : g_low
				assign bucket = h_q[BW-1:0];
			end
		end else begin : g_rem
			// remainder by reciprocal: the quotient estimate is low by at most one,
			// so one compare and subtract finishes it
			localparam int unsigned SH = 31 + BW;
			localparam logic [31:0] RECIP = 32'((64'd1 << SH) / 64'(BUCKETS));
			localparam logic [31:0] B32 = 32'(BUCKETS);

			logic        run_q;
			logic        mul_q;
			logic        done_q;
			logic [63:0] prod_q;
			logic [31:0] r_q;
			logic [31:0] q_est;

			assign q_est = 32'(prod_q[63:SH]);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q  <= 1'b0;
					mul_q  <= 1'b0;
					done_q <= 1'b0;
				end else begin
					run_q  <= start;
					mul_q  <= run_q;
					done_q <= mul_q;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					h_q <= 32'(key * HASH_MULT);
				end
				if (run_q) begin
					prod_q <= 64'(h_q) * 64'(RECIP);
				end
				if (mul_q) begin
					r_q <= h_q - 32'(q_est * B32);
				end
			end

			assign done   = done_q;
			assign bucket = (r_q >= B32) ? BW'(r_q - B32) : BW'(r_q);
		end
	endgenerate

endmodule

[rtl/multiplicative_hash_map.sv]
// Channel | Direction | Word    | Handshake
// req     | in        | req_t   | req_valid / req_stall
// rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// One operation at a time: accept, hash, then one row read-modify-write.
// When BUCKETS is not a power of two, the bucket remainder takes a reciprocal
// multiply, a back multiply and a correction.
// After reset a clearing pass zeroes every row; req_stall is high for its length.
// A result held by rsp_stall lets the next item be accepted and hashed, then holds that item's write-back in S_UPDATE.
`include "multiplicative_hash_map_defines.svh"

module multiplicative_hash_map #(
	parameter int unsigned BUCKETS = mhm_pkg::BUCKETS_DEF,
	parameter int unsigned WAYS    = mhm_pkg::WAYS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mhm_pkg::req_t req,
	input  logic          req_valid,
	output logic          req_stall,
	output mhm_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_stall
);
	import mhm_pkg::*;

	localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned ROW_W = WAYS * 65;
	localparam logic [BW-1:0] CLR_LAST = BW'(BUCKETS - 1);

	state_t        state_q, state_d;
	logic [BW-1:0] clr_q;
	req_t          op_q;
	logic [BW-1:0] bucket_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          hash_start;
	logic          hash_done;
	logic [BW-1:0] hash_bucket;

	// one row per bucket: {valid bits, keys, handles}
	logic [ROW_W-1:0] mem [BUCKETS];
	logic [ROW_W-1:0] rdata_q;
	logic             mem_we;
	logic [BW-1:0]    mem_waddr;
	logic [ROW_W-1:0] mem_wdata;

	logic [WAYS-1:0]        row_valid;
	logic [WAYS-1:0][31:0]  row_key;
	logic [WAYS-1:0][31:0]  row_hnd;
	logic [WAYS-1:0]        new_valid;
	logic [WAYS-1:0][31:0]  new_key;
	logic [WAYS-1:0][31:0]  new_hnd;
	logic [WAYS-1:0]        match_vec;
	logic [IW-1:0]          match_idx;
	logic [IW-1:0]          free_idx;
	logic                   any_match;
	logic                   any_free;
	rsp_t                   upd_rsp;
	logic                   rsp_load;

	mhm_hash #(
		.BUCKETS(BUCKETS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   ($unsigned(req.key)),
		.done  (hash_done),
		.bucket(hash_bucket)
	);

	assign row_valid = rdata_q[ROW_W-1 -: WAYS];
	assign row_key   = rdata_q[2*WAYS*32-1 : WAYS*32];
	assign row_hnd   = rdata_q[WAYS*32-1 : 0];

	// lowest matching way and lowest free way
	always_comb begin
		match_vec = '0;
		match_idx = '0;
		free_idx  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match_vec[w] = row_valid[w] && (row_key[w] == $unsigned(op_q.key));
			if (match_vec[w]) begin
				match_idx = IW'(w);
			end
			if (!row_valid[w]) begin
				free_idx = IW'(w);
			end
		end
		any_match = |match_vec;
		any_free  = ~&row_valid;
	end

	always_comb begin
		new_valid            = row_valid;
		new_key              = row_key;
		new_hnd              = row_hnd;
		upd_rsp.status       = STS_MISS;
		upd_rsp.found_handle = '0;
		unique case (op_q.func)
			FN_FIND: begin
				if (any_match) begin
					upd_rsp.status       = STS_OK;
					upd_rsp.found_handle = row_hnd[match_idx];
				end
			end
			FN_INSERT: begin
				if (any_match) begin
					new_hnd[match_idx] = op_q.handle;
					upd_rsp.status     = STS_OK;
				end else if (any_free) begin
					new_valid[free_idx] = 1'b1;
					new_key[free_idx]   = $unsigned(op_q.key);
					new_hnd[free_idx]   = op_q.handle;
					upd_rsp.status      = STS_OK;
				end else begin
					upd_rsp.status = STS_FULL;
				end
			end
			FN_REMOVE: begin
				if (any_match) begin
					new_valid[match_idx] = 1'b0;
					upd_rsp.status       = STS_OK;
				end
			end
			default: begin
				upd_rsp.status = STS_MISS;
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		hash_start = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = bucket_q;
		mem_wdata  = {new_valid, new_key, new_hnd};
		rsp_load   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == CLR_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					hash_start = 1'b1;
					state_d    = S_HASH;
				end
			end
			S_HASH: begin
				if (hash_done) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				// write back only once the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					mem_we   = 1'b1;
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hash_start) begin
			op_q <= req;
		end
		if (hash_done) begin
			bucket_q <= hash_bucket;
		end
		if (rsp_load) begin
			rsp_q <= upd_rsp;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (hash_done) begin
			rdata_q <= mem[hash_bucket];
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	`MHM_CHECK(a_done_in_hash, hash_done |-> state_q == S_HASH)
	`MHM_CHECK(a_we_phase, mem_we |-> (state_q == S_CLEAR || state_q == S_UPDATE))
	`MHM_CHECK(a_one_match, state_q == S_UPDATE |-> $countones(match_vec) <= 1)
	`MHM_CHECK(a_full_insert, (state_q == S_UPDATE && upd_rsp.status == STS_FULL) |-> (op_q.func == FN_INSERT && &row_valid))
	`MHM_CHECK(a_rsp_from_update, $rose(rsp_valid_q) |-> $past(state_q == S_UPDATE))
	`MHM_CHECK_ALL(a_reset_clears, !arst_n ##1 !arst_n |-> (state_q == S_CLEAR && !rsp_valid_q))

endmodule

[tb/tb.sv]
module tb;
	import mhm_pkg::*;

	localparam int unsigned NB = BUCKETS_DEF;
	localparam int unsigned NW = WAYS_DEF;

	typedef struct {
		req_t w;
		bit   drain;   // hold this word back until every result is in
	} op_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	req_t req = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall = 1'b0;

	op_item_t ops_q[$];
	rsp_t     rsp_due[$];

	bit          shadow_valid[NB*NW];
	logic [31:0] shadow_key[NB*NW];
	logic [31:0] shadow_handle[NB*NW];

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned err_cnt = 0;
	int unsigned hold_left = 0;
	bit          hold_go = 1'b0;
	logic [31:0] key_pool[48];

	multiplicative_hash_map u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// table predictor: one lookup / update per word, one result per word
	function automatic rsp_t map_apply(req_t r);
		logic [31:0] prod;
		int unsigned base;
		int          hit_way;
		int          free_way;
		rsp_t        o;
		prod = $unsigned(r.key) * HASH_MULT;
		base = (prod % NB) * NW;
		hit_way = -1;
		free_way = -1;
		o.status = STS_MISS;
		o.found_handle = '0;
		for (int w = 0; w < NW; w++) begin
			if (shadow_valid[base + w]) begin
				if (hit_way < 0 && shadow_key[base + w] == $unsigned(r.key))
					hit_way = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		case (r.func)
			FN_FIND: begin
				if (hit_way >= 0) begin
					o.status = STS_OK;
					o.found_handle = shadow_handle[base + hit_way];
				end
			end
			FN_INSERT: begin
				if (hit_way >= 0) begin
					shadow_handle[base + hit_way] = r.handle;
					o.status = STS_OK;
				end else if (free_way >= 0) begin
					shadow_valid[base + free_way] = 1'b1;
					shadow_key[base + free_way] = r.key;
					shadow_handle[base + free_way] = r.handle;
					o.status = STS_OK;
				end else begin
					o.status = STS_FULL;
				end
			end
			FN_REMOVE: begin
				if (hit_way >= 0) begin
					shadow_valid[base + hit_way] = 1'b0;
					o.status = STS_OK;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic void add_op(logic [1:0] f, logic [31:0] k, logic [31:0] h,
			bit drain = 1'b0);
		op_item_t it;
		it.w.func = f;
		it.w.key = k;
		it.w.handle = h;
		it.drain = drain;
		ops_q.push_back(it);
	endfunction

	function automatic logic [31:0] pick_key();
		if ($urandom_range(99) < 80)
			return key_pool[$urandom_range(47)];
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_handle();
		case ($urandom_range(19))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [1:0] pick_func();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			return FN_INSERT;
		if (r < 80)
			return FN_FIND;
		if (r < 97)
			return FN_REMOVE;
		return FN_RSVD;   // unused code, must act as a no-op miss
	endfunction

	task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall);
		@(negedge clk);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++)
			add_op(pick_func(), pick_key(), pick_handle(), $urandom_range(99) < 2);
		wait (ops_q.size() == 0 && !req_valid && rsp_due.size() == 0);
	endtask

	// driver
	always @(posedge clk) begin : drive
		bit busy;
		busy = req_valid;
		if (req_valid && !req_stall) begin
			rsp_due.push_back(map_apply(req));
			busy = 1'b0;
		end
		if (!busy) begin
			if (arst_n && ops_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
					(!ops_q[0].drain || (rsp_due.size() == 0 && !req_valid))) begin
				req <= ops_q[0].w;
				req_valid <= 1'b1;
				void'(ops_q.pop_front());
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left <= 400;
			hold_go <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		rsp_t exp_w;
		if (rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result word: status %0d handle %h",
						rsp.status, rsp.found_handle);
			end else begin
				exp_w = rsp_due.pop_front();
				if (rsp.status !== exp_w.status || rsp.found_handle !== exp_w.found_handle) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: exp status %0d handle %h, got status %0d handle %h",
							exp_w.status, exp_w.found_handle, rsp.status, rsp.found_handle);
				end
			end
		end
		rsp_stall <= arst_n && ((hold_left != 0) || ($urandom_range(99) < stall_pct));
	end

	initial begin
		logic [9:0] hot_low;
		for (int i = 0; i < 48; i++) begin
			if (i % 6 == 0)
				hot_low = 10'($urandom_range(1023));
			key_pool[i] = {22'($urandom_range(32'h3F_FFFF)), hot_low};
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extreme keys, empty buckets, one full bucket (low 10 bits 0x155)
		add_op(FN_FIND,   32'h8000_0000, 32'h1234_5678);
		add_op(FN_REMOVE, 32'h7FFF_FFFF, 32'h0);
		add_op(FN_INSERT, 32'h8000_0000, 32'h0000_0000);
		add_op(FN_FIND,   32'h8000_0000, 32'hFFFF_FFFF);
		add_op(FN_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		add_op(FN_FIND,   32'h7FFF_FFFF, 32'h0);
		add_op(FN_INSERT, 32'h0000_0155, 32'hAAAA_0001);
		add_op(FN_INSERT, 32'hFFFF_FD55, 32'hAAAA_0002);
		add_op(FN_INSERT, 32'h1234_5955, 32'hAAAA_0003);
		add_op(FN_INSERT, 32'hCAFE_1155, 32'hAAAA_0004);
		add_op(FN_INSERT, 32'h7777_7D55, 32'hAAAA_0005);  // bucket full
		add_op(FN_FIND,   32'h7777_7D55, 32'h0);
		add_op(FN_INSERT, 32'hFFFF_FD55, 32'h5555_5555);  // replace in full bucket
		add_op(FN_FIND,   32'hFFFF_FD55, 32'h0);
		add_op(FN_REMOVE, 32'h1234_5955, 32'h0);
		add_op(FN_REMOVE, 32'h1234_5955, 32'h0);
		add_op(FN_INSERT, 32'h7777_7D55, 32'hAAAA_0005);  // lowest free way
		add_op(FN_FIND,   32'h7777_7D55, 32'h0);
		add_op(FN_RSVD,   32'h0000_0155, 32'hFFFF_FFFF);
		add_op(FN_FIND,   32'h0000_0155, 32'h0);
		add_op(FN_REMOVE, 32'h0000_0155, 32'h0);
		add_op(FN_FIND,   32'h0000_0155, 32'h0);
		add_op(FN_FIND,   32'h0000_0000, 32'h0);
		wait (ops_q.size() == 0 && !req_valid && rsp_due.size() == 0);

		// receiver holds off while the sender keeps pushing
		@(negedge clk);
		hold_go = 1'b1;
		run_phase(40, 0, 0);

		run_phase(200, 0, 0);
		run_phase(200, 68, 0);
		run_phase(200, 0, 68);
		run_phase(200, 27, 27);

		repeat (50) @(posedge clk);
		if (err_cnt == 0 && rsp_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
